// File: design/rexb_pkg.sv
// Shared types, constants and codes for the randomized exponential backoff engine.
package rexb_pkg;

	localparam int INTERVAL_BITS = 24;
	localparam int FRACTION_BITS = 8;
	localparam int ELAPSED_BITS  = 32;
	localparam int RAND_BITS     = 16;
	localparam int CFG_DATA_BITS = 32;
	localparam int CFG_IDX_BITS  = 3;

	localparam int MULT_BITS = FRACTION_BITS + 4;
	localparam int WAIT_BITS = INTERVAL_BITS + 1;
	localparam int DQ_BITS   = INTERVAL_BITS + FRACTION_BITS;
	localparam int GROW_BITS = INTERVAL_BITS + MULT_BITS;
	localparam int SPAN_RAW  = INTERVAL_BITS + FRACTION_BITS + 1;
	localparam int SPAN_BITS = (SPAN_RAW > RAND_BITS + 1) ? SPAN_RAW : RAND_BITS + 1;
	localparam int SPAN_HI_BITS = SPAN_BITS - RAND_BITS;

	localparam int MUL_A_BITS = (INTERVAL_BITS > SPAN_HI_BITS) ? INTERVAL_BITS : SPAN_HI_BITS;
	localparam int MUL_B_BITS = (MULT_BITS > RAND_BITS) ? MULT_BITS : RAND_BITS;
	localparam int PROD_BITS  = MUL_A_BITS + MUL_B_BITS;

	localparam logic [INTERVAL_BITS-1:0] INITIAL_RESET = INTERVAL_BITS'(500);
	localparam logic [INTERVAL_BITS-1:0] MAX_INT_RESET = INTERVAL_BITS'(60000);
	localparam logic [ELAPSED_BITS-1:0]  MAX_ELA_RESET = ELAPSED_BITS'(900000);
	localparam logic [MULT_BITS-1:0]     MULT_RESET    = MULT_BITS'(384);
	localparam logic [FRACTION_BITS-1:0] FACTOR_RESET  = FRACTION_BITS'(128);

	typedef enum logic [1:0] {
		MODE_TICK    = 2'd0,
		MODE_REQUEST = 2'd1,
		MODE_RESTART = 2'd2
	} mode_t;

	typedef enum logic [CFG_IDX_BITS-1:0] {
		CFG_INITIAL_INTERVAL = 3'd0,
		CFG_MAX_INTERVAL     = 3'd1,
		CFG_MAX_ELAPSED      = 3'd2,
		CFG_MULTIPLIER       = 3'd3,
		CFG_RANDOM_FACTOR    = 3'd4
	} cfg_index_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DQ,
		ST_SPAN,
		ST_HI,
		ST_LO,
		ST_FIN
	} state_t;

	typedef struct packed {
		logic [1:0]           mode;
		logic [RAND_BITS-1:0] random_fraction;
	} item_t;

	typedef struct packed {
		logic [WAIT_BITS-1:0]     wait_millis;
		logic [INTERVAL_BITS-1:0] next_interval;
		logic                     elapsed_expired;
	} result_t;

	typedef struct packed {
		logic                  en;
		logic [MUL_A_BITS-1:0] a;
		logic [MUL_B_BITS-1:0] b;
	} mul_op_t;

endpackage

// File: design/rexb_mul.sv
// Shared unsigned multiplier with a registered product.
module rexb_mul (
	input  logic                            clk,
	input  rexb_pkg::mul_op_t               op,
	output logic [rexb_pkg::PROD_BITS-1:0]  prod_q
);
	import rexb_pkg::*;

	// Hold the product until the sequencer issues the next operation.
	always_ff @(posedge clk) begin
		if (op.en) begin
			prod_q <= PROD_BITS'(op.a) * PROD_BITS'(op.b);
		end
	end

endmodule

// File: design/randomized_exponential_backoff_top.sv
// Top level of the randomized exponential backoff engine: sequencer, state and result register.
//
// Each transfer on the item channel is a one-millisecond tick, a restart or a request for the
// next retry wait, and each one yields exactly one result transfer. Ticks, restarts, the unused
// mode code and requests made after the elapsed limit has passed finish in the accept cycle:
// the result is registered at that edge and a new item can be taken on the next cycle, provided
// the result register is empty or its result transfers at that same edge. A live request
// occupies the block from its accept edge through ST_DQ, ST_SPAN, ST_HI, ST_LO and ST_FIN to the
// edge that registers its result, and the next item is taken only after that, as its four products
// (factor times interval, multiplier times interval, and the random fraction times the upper and
// lower halves of the spread) all pass one by one through a single registered multiplier; the
// item channel stalls during that time and again if the result register is still occupied when
// the wait is ready. The wait is drawn from [I - d, I + d + 1) with d = factor * I in Q.8 fixed
// point, truncated, and the interval then grows by the Q4.8 multiplier, clamped to the maximum.
// Configuration writes are always ready and take effect on the next item; writing the initial
// interval affects the current interval only at the next restart.
module randomized_exponential_backoff_top (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                item_valid,
	output logic                                item_stall,
	input  rexb_pkg::item_t                     item,
	output logic                                result_valid,
	input  logic                                result_stall,
	output rexb_pkg::result_t                   result,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [rexb_pkg::CFG_IDX_BITS-1:0]   cfg_index,
	input  logic [rexb_pkg::CFG_DATA_BITS-1:0]  cfg_data
);
	import rexb_pkg::*;

	// Configuration registers
	logic [INTERVAL_BITS-1:0] init_q;
	logic [INTERVAL_BITS-1:0] max_int_q;
	logic [ELAPSED_BITS-1:0]  max_ela_q;
	logic [MULT_BITS-1:0]     mult_q;
	logic [FRACTION_BITS-1:0] factor_q;

	// Architectural state
	logic [INTERVAL_BITS-1:0] cur_q;
	logic [ELAPSED_BITS-1:0]  elapsed_q;

	// Sequencer and request working registers
	state_t                   state_q, state_d;
	logic [RAND_BITS-1:0]     rand_q;
	logic [DQ_BITS-1:0]       lo_q;
	logic [SPAN_BITS-1:0]     span_q;
	logic [SPAN_BITS-1:0]     acc_q;

	// Result register
	result_t                  result_q;
	logic                     result_valid_q;

	// Shared multiplier
	mul_op_t                  mul_op;
	logic [PROD_BITS-1:0]     prod_q;

	// Combinational helpers
	logic                     out_free;
	logic                     accept;
	logic                     load_out;
	result_t                  out_d;
	logic [ELAPSED_BITS-1:0]  elapsed_inc;
	logic                     expired_now;
	logic [DQ_BITS-1:0]       dq;
	logic [SPAN_BITS-1:0]     scaled;
	logic                     clamp;

	rexb_mul u_mul (
		.clk    (clk),
		.op     (mul_op),
		.prod_q (prod_q)
	);

	assign cfg_ready    = 1'b1;
	assign result_valid = result_valid_q;
	assign result       = result_q;

	// The result register is free when empty or being drained this cycle.
	assign out_free    = !result_valid_q || !result_stall;
	assign accept      = item_valid && !item_stall;
	assign elapsed_inc = (elapsed_q != '1) ? elapsed_q + ELAPSED_BITS'(1) : elapsed_q;
	assign expired_now = elapsed_q > max_ela_q;

	// Product views: dq lives in the product after ST_DQ, the growth product after ST_SPAN,
	// and the low spread term after ST_LO.
	assign dq     = prod_q[DQ_BITS-1:0];
	assign clamp  = prod_q[GROW_BITS-1:0] >= GROW_BITS'({max_int_q, FRACTION_BITS'(0)});
	assign scaled = acc_q + SPAN_BITS'(prod_q[RAND_BITS +: RAND_BITS]);

	// Next state, handshake and multiplier operand selection
	always_comb begin
		state_d    = state_q;
		item_stall = 1'b1;
		load_out   = 1'b0;
		mul_op     = '0;
		out_d      = '0;
		unique case (state_q)
			ST_IDLE: begin
				item_stall = !out_free;
				if (item_valid && out_free) begin
					unique case (mode_t'(item.mode))
						MODE_TICK: begin
							load_out              = 1'b1;
							out_d.next_interval   = cur_q;
							out_d.elapsed_expired = elapsed_inc > max_ela_q;
						end
						MODE_RESTART: begin
							// Elapsed clears to zero, which can never exceed the limit.
							load_out            = 1'b1;
							out_d.next_interval = init_q;
						end
						MODE_REQUEST: begin
							if (expired_now) begin
								load_out              = 1'b1;
								out_d.wait_millis     = WAIT_BITS'(cur_q);
								out_d.next_interval   = cur_q;
								out_d.elapsed_expired = 1'b1;
							end else begin
								state_d = ST_DQ;
							end
						end
						default: begin
							// Unused mode code: report state, change nothing.
							load_out              = 1'b1;
							out_d.next_interval   = cur_q;
							out_d.elapsed_expired = expired_now;
						end
					endcase
				end
			end
			ST_DQ: begin
				mul_op.en = 1'b1;
				mul_op.a  = MUL_A_BITS'(cur_q);
				mul_op.b  = MUL_B_BITS'(factor_q);
				state_d   = ST_SPAN;
			end
			ST_SPAN: begin
				// Spread terms are latched from dq while the growth product is formed.
				mul_op.en = 1'b1;
				mul_op.a  = MUL_A_BITS'(cur_q);
				mul_op.b  = MUL_B_BITS'(mult_q);
				state_d   = ST_HI;
			end
			ST_HI: begin
				mul_op.en = 1'b1;
				mul_op.a  = MUL_A_BITS'(span_q[SPAN_BITS-1:RAND_BITS]);
				mul_op.b  = MUL_B_BITS'(rand_q);
				state_d   = ST_LO;
			end
			ST_LO: begin
				mul_op.en = 1'b1;
				mul_op.a  = MUL_A_BITS'(span_q[RAND_BITS-1:0]);
				mul_op.b  = MUL_B_BITS'(rand_q);
				state_d   = ST_FIN;
			end
			ST_FIN: begin
				// Hold the finished wait until the result register frees up.
				if (out_free) begin
					load_out            = 1'b1;
					out_d.wait_millis   = scaled[FRACTION_BITS +: WAIT_BITS];
					out_d.next_interval = cur_q;
					state_d             = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Configuration registers: mask each write to the register width.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			init_q    <= INITIAL_RESET;
			max_int_q <= MAX_INT_RESET;
			max_ela_q <= MAX_ELA_RESET;
			mult_q    <= MULT_RESET;
			factor_q  <= FACTOR_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index_t'(cfg_index))
				CFG_INITIAL_INTERVAL: init_q    <= cfg_data[INTERVAL_BITS-1:0];
				CFG_MAX_INTERVAL:     max_int_q <= cfg_data[INTERVAL_BITS-1:0];
				CFG_MAX_ELAPSED:      max_ela_q <= cfg_data[ELAPSED_BITS-1:0];
				CFG_MULTIPLIER:       mult_q    <= cfg_data[MULT_BITS-1:0];
				CFG_RANDOM_FACTOR:    factor_q  <= cfg_data[FRACTION_BITS-1:0];
				default: begin
				end
			endcase
		end
	end

	// Interval and elapsed counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q     <= INITIAL_RESET;
			elapsed_q <= '0;
		end else if (accept) begin
			priority if (mode_t'(item.mode) == MODE_TICK) begin
				elapsed_q <= elapsed_inc;
			end else if (mode_t'(item.mode) == MODE_RESTART) begin
				elapsed_q <= '0;
				cur_q     <= init_q;
			end else begin
			end
		end else if (state_q == ST_HI) begin
			// Apply growth from the product formed in ST_SPAN, clamped to the ceiling.
			cur_q <= clamp ? max_int_q : prod_q[FRACTION_BITS +: INTERVAL_BITS];
		end
	end

	// Request working registers
	always_ff @(posedge clk) begin
		if (accept) begin
			rand_q <= item.random_fraction;
		end
		if (state_q == ST_SPAN) begin
			lo_q   <= {cur_q, FRACTION_BITS'(0)} - dq;
			span_q <= SPAN_BITS'({dq, 1'b0}) + (SPAN_BITS'(1) << FRACTION_BITS);
		end
		if (state_q == ST_LO) begin
			// Upper spread term is exact: fraction times high half, no truncation.
			acc_q <= SPAN_BITS'(lo_q) + prod_q[SPAN_BITS-1:0];
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (load_out) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			result_q <= out_d;
		end
	end

endmodule

// File: tb/randomized_exponential_backoff_top_test.sv
// Self-checking testbench for the randomized exponential backoff engine top level.
module randomized_exponential_backoff_top_test;
	import rexb_pkg::*;

	// Codes the package leaves unnamed: the spare mode value and a spare register slot.
	localparam logic [1:0]              MODE_UNUSED      = 2'd3;
	localparam logic [CFG_IDX_BITS-1:0] CFG_UNUSED_INDEX = 3'd7;

	// A live request, with the drawn result stall and sender gap, finishes well within
	// QUIET_LIMIT, so reaching it with no transfer at all means a hang.
	localparam int QUIET_LIMIT   = 400;
	localparam int SETTLE_CYCLES = 10;
	localparam int PHASE_COUNT   = 8;
	localparam int PHASE_ITEMS   = 60;

	logic                     clk          = 1'b0;
	logic                     arst_n       = 1'b0;
	logic                     item_valid   = 1'b0;
	logic                     item_stall;
	item_t                    item         = '0;
	logic                     result_valid;
	logic                     result_stall = 1'b0;
	result_t                  result;
	logic                     cfg_valid    = 1'b0;
	logic                     cfg_ready;
	logic [CFG_IDX_BITS-1:0]  cfg_index    = '0;
	logic [CFG_DATA_BITS-1:0] cfg_data     = '0;

	// Shadow copy of the configuration registers and of the engine state.
	logic [INTERVAL_BITS-1:0] initial_reg  = INITIAL_RESET;
	logic [INTERVAL_BITS-1:0] max_int_reg  = MAX_INT_RESET;
	logic [ELAPSED_BITS-1:0]  max_ela_reg  = MAX_ELA_RESET;
	logic [MULT_BITS-1:0]     mult_reg     = MULT_RESET;
	logic [FRACTION_BITS-1:0] factor_reg   = FACTOR_RESET;
	logic [INTERVAL_BITS-1:0] interval_now = INITIAL_RESET;
	logic [ELAPSED_BITS-1:0]  elapsed_ms   = '0;

	item_t   pending_items[$];
	result_t expected_results[$];

	int items_queued   = 0;
	int items_accepted = 0;
	int failures       = 0;
	int quiet_cycles   = 0;
	int item_gap       = 0;
	int stall_left     = 0;
	bit idle_on        = 1'b1;
	bit item_fired     = 1'b0;
	bit result_fired   = 1'b0;

	randomized_exponential_backoff_top u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	// Advance the shadow state by one item and return the result it must produce.
	// All products are formed at 64 bits so nothing truncates before the final shift.
	function automatic result_t next_backoff(item_t it);
		logic [63:0] cur, dq, lo, span, scaled, prod, frac;
		result_t     res;
		res  = '0;
		cur  = 64'(interval_now);
		frac = 64'(it.random_fraction);
		case (it.mode)
			MODE_TICK: begin
				// Saturate rather than wrap.
				if (elapsed_ms != '1)
					elapsed_ms = elapsed_ms + 1'b1;
			end
			MODE_RESTART: begin
				elapsed_ms   = '0;
				interval_now = initial_reg;
			end
			MODE_REQUEST: begin
				if (elapsed_ms > max_ela_reg) begin
					// Past the limit: report the interval as is and leave it alone.
					res.wait_millis = WAIT_BITS'(interval_now);
				end else begin
					// Draw from [I - d, I + d + 1) in Q.8, splitting the span so the
					// fraction product is exact.
					dq     = 64'(factor_reg) * cur;
					lo     = (cur << FRACTION_BITS) - dq;
					span   = (dq << 1) + (64'd1 << FRACTION_BITS);
					scaled = lo + frac * (span >> RAND_BITS)
						+ ((frac * (span & 64'hFFFF)) >> RAND_BITS);
					res.wait_millis = WAIT_BITS'(scaled >> FRACTION_BITS);
					// Grow, clamping to the ceiling; a zero ceiling forces zero.
					prod = cur * 64'(mult_reg);
					if (prod >= (64'(max_int_reg) << FRACTION_BITS))
						interval_now = max_int_reg;
					else
						interval_now = INTERVAL_BITS'(prod >> FRACTION_BITS);
				end
			end
			default: ;
		endcase
		res.next_interval   = interval_now;
		res.elapsed_expired = elapsed_ms > max_ela_reg;
		return res;
	endfunction

	function automatic void check_field(string field, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			failures++;
			$display("%0t mismatch on %s: expected %0d actual %0d", $time, field, want, got);
		end
	endfunction

	// Sample both channels at the rising edge. Check results before predicting, since a
	// result can only belong to an item taken at an earlier edge.
	always @(posedge clk) begin
		result_t want;
		item_fired   = arst_n && item_valid && !item_stall;
		result_fired = arst_n && result_valid && !result_stall;
		if (result_fired) begin
			if (expected_results.size() == 0) begin
				failures++;
				$display("%0t unexpected result: expected none actual %h", $time, result);
			end else begin
				want = expected_results.pop_front();
				check_field("wait_millis", 32'(want.wait_millis), 32'(result.wait_millis));
				check_field("next_interval", 32'(want.next_interval),
					32'(result.next_interval));
				check_field("elapsed_expired", 32'(want.elapsed_expired),
					32'(result.elapsed_expired));
			end
		end
		if (item_fired) begin
			expected_results.push_back(next_backoff(item));
			items_accepted++;
		end
		// Watchdog: any transfer on any channel, or reset, counts as progress.
		if (!arst_n || item_fired || result_fired || (cfg_valid && cfg_ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// Item driver: drop the payload after its transfer, wait out the drawn gap, then
	// present the next one. Compute the next values first so each signal gets one update.
	always @(negedge clk) begin
		logic  next_valid;
		item_t next_item;
		next_valid = item_valid;
		next_item  = item;
		if (item_fired)
			next_valid = 1'b0;
		if (!next_valid && arst_n) begin
			if (item_gap > 0) begin
				item_gap--;
			end else if (pending_items.size() > 0) begin
				next_item  = pending_items.pop_front();
				next_valid = 1'b1;
				item_gap   = idle_on ? $urandom_range(0, 3) : 0;
			end
		end
		item_valid <= next_valid;
		item       <= next_item;
	end

	// Result receiver: after each transfer, draw how long to hold off the next one.
	always @(negedge clk) begin
		if (result_fired)
			stall_left = idle_on ? $urandom_range(0, 3) : 0;
		if (stall_left > 0) begin
			result_stall <= 1'b1;
			stall_left--;
		end else begin
			result_stall <= 1'b0;
		end
	end

	task automatic queue_item(logic [1:0] mode, logic [RAND_BITS-1:0] frac);
		pending_items.push_back(item_t'{mode: mode, random_fraction: frac});
		items_queued++;
	endtask

	// Write one register and mirror it in the shadow copy at the transfer edge.
	task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] value);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			CFG_INITIAL_INTERVAL: initial_reg = INTERVAL_BITS'(value);
			CFG_MAX_INTERVAL:     max_int_reg = INTERVAL_BITS'(value);
			CFG_MAX_ELAPSED:      max_ela_reg = ELAPSED_BITS'(value);
			CFG_MULTIPLIER:       mult_reg    = MULT_BITS'(value);
			CFG_RANDOM_FACTOR:    factor_reg  = FRACTION_BITS'(value);
			default: ;
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic load_config(logic [31:0] init, logic [31:0] max_int, logic [31:0] max_ela,
		logic [31:0] mult, logic [31:0] factor);
		write_reg(CFG_INITIAL_INTERVAL, init);
		write_reg(CFG_MAX_INTERVAL, max_int);
		write_reg(CFG_MAX_ELAPSED, max_ela);
		write_reg(CFG_MULTIPLIER, mult);
		write_reg(CFG_RANDOM_FACTOR, factor);
	endtask

	// Hold until every queued item is taken and answered, then let the pipeline go quiet.
	task automatic settle();
		while (items_accepted != items_queued || expected_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Bias toward the ends of the range and toward small values near the low end.
	function automatic logic [31:0] draw_value(logic [31:0] lo, logic [31:0] hi);
		case ($urandom_range(0, 7))
			0:       return lo;
			1:       return hi;
			2, 3:    return (hi - lo > 1000) ? lo + $urandom_range(0, 1000)
				: $urandom_range(lo, hi);
			default: return $urandom_range(lo, hi);
		endcase
	endfunction

	initial begin
		int                   phase, n, roll;
		logic [1:0]           mode;
		logic [RAND_BITS-1:0] frac;

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Reset configuration: both fraction extremes, a tick, the spare mode code.
		queue_item(MODE_RESTART, 16'h0000);
		queue_item(MODE_REQUEST, 16'h0000);
		queue_item(MODE_REQUEST, 16'hFFFF);
		queue_item(MODE_TICK, 16'h0000);
		queue_item(MODE_UNUSED, 16'hFFFF);
		queue_item(MODE_REQUEST, 16'h1234);
		queue_item(MODE_TICK, 16'hFFFF);
		queue_item(MODE_RESTART, 16'h8000);
		settle();

		// Widest interval, largest multiplier and spread; expire after a single tick.
		load_config(32'hFFFFFF, 32'hFFFFFF, 32'd0, 32'hFFF, 32'hFF);
		queue_item(MODE_RESTART, 16'h0000);
		queue_item(MODE_REQUEST, 16'hFFFF);
		queue_item(MODE_REQUEST, 16'h0000);
		queue_item(MODE_TICK, 16'h0000);
		queue_item(MODE_REQUEST, 16'hFFFF);
		queue_item(MODE_RESTART, 16'h0000);
		queue_item(MODE_REQUEST, 16'h8000);
		settle();

		// Zero ceiling collapses the interval to zero; then request with a zero interval.
		load_config(32'd1000, 32'd0, 32'hFFFFFFFF, 32'd0, 32'd0);
		queue_item(MODE_RESTART, 16'h0000);
		queue_item(MODE_REQUEST, 16'h8000);
		queue_item(MODE_REQUEST, 16'hFFFF);
		queue_item(MODE_TICK, 16'h5555);
		queue_item(MODE_UNUSED, 16'hAAAA);
		settle();

		// Multiplier below one: the interval shrinks on each request.
		load_config(32'd1000, 32'd60000, 32'd900000, 32'd200, 32'd64);
		queue_item(MODE_RESTART, 16'h0000);
		queue_item(MODE_REQUEST, RAND_BITS'($urandom()));
		queue_item(MODE_REQUEST, RAND_BITS'($urandom()));
		queue_item(MODE_REQUEST, RAND_BITS'($urandom()));
		settle();

		// Random phases: each opens with a restart and then runs ticks and requests,
		// with a little noise from stray restarts and the spare mode code.
		for (phase = 0; phase < PHASE_COUNT; phase++) begin
			idle_on = (phase % 3) != 2;
			load_config(draw_value(1, 32'hFFFFFF), draw_value(1, 32'hFFFFFF),
				$urandom_range(0, 1) ? draw_value(0, 60) : draw_value(0, 32'hFFFFFFFF),
				($urandom_range(0, 3) == 0) ? draw_value(0, 255) : draw_value(256, 4095),
				draw_value(0, 255));
			if (phase == 3)
				write_reg(CFG_UNUSED_INDEX, $urandom());
			queue_item(MODE_RESTART, RAND_BITS'($urandom()));
			for (n = 1; n < PHASE_ITEMS; n++) begin
				roll = $urandom_range(0, 99);
				if (roll < 50)
					mode = MODE_TICK;
				else if (roll < 85)
					mode = MODE_REQUEST;
				else if (roll < 95)
					mode = MODE_RESTART;
				else
					mode = MODE_UNUSED;
				case ($urandom_range(0, 9))
					0:       frac = '0;
					1:       frac = '1;
					default: frac = RAND_BITS'($urandom());
				endcase
				queue_item(mode, frac);
			end
			settle();
		end

		if (failures == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
